### design/fsx_pkg.sv
// Package for the framing encoder: job record passed from front to back,
// sequencer phases and the framing byte constants. No dependencies.
`timescale 1ns / 1ps

package fsx_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] END_BYTE   = 8'hFE;
  localparam logic [7:0] ESC_BYTE   = 8'hFD;
  localparam logic [7:0] ALT_BYTE   = 8'hCC;
  localparam logic [7:0] ALT_CODE   = 8'h03;

  // One classified payload byte, with the checksum as it stands after it
  typedef struct packed {
    logic       start;
    logic       last;
    logic [7:0] data;
    logic [7:0] chk_hi;
    logic [7:0] chk_lo;
  } job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_DATA,
    PH_CHI,
    PH_CLO,
    PH_END
  } phase_t;

  // True when the byte must go out as an escape pair
  function automatic logic needs_esc(input logic [7:0] b);
    return (b == ALT_BYTE) || (b >= ESC_BYTE);
  endfunction

  // Second byte of an escape pair
  function automatic logic [7:0] esc_code(input logic [7:0] b);
    logic [7:0] code;
    if (b == ALT_BYTE) begin
      code = ALT_CODE;
    end else begin
      code = b - ESC_BYTE;
    end
    return code;
  endfunction

endpackage

### design/fsx_front.sv
// Front end: accepts payload bytes, tracks packet start, position parity and
// the two XOR checksum bytes, and emits one job per byte. Uses fsx_pkg.
`timescale 1ns / 1ps

module fsx_front
  import fsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       job_push,
  output job_t       job_data,
  input  logic       job_full
);

  logic       first_r, first_nxt;
  logic       odd_r, odd_nxt;
  logic [7:0] chk_hi_r, chk_hi_nxt;
  logic [7:0] chk_lo_r, chk_lo_nxt;
  logic [7:0] hi_upd, lo_upd;

  assign in_ready = !job_full;
  assign job_push = in_valid && !job_full;

  // Fold the byte into the checksum half chosen by its position
  assign hi_upd = odd_r ? chk_hi_r : (chk_hi_r ^ in_byte);
  assign lo_upd = odd_r ? (chk_lo_r ^ in_byte) : chk_lo_r;

  always_comb begin
    job_data.start  = first_r;
    job_data.last   = in_end;
    job_data.data   = in_byte;
    job_data.chk_hi = hi_upd;
    job_data.chk_lo = lo_upd;
  end

  // Advance packet state; clear it after the final byte
  always_comb begin
    first_nxt  = first_r;
    odd_nxt    = odd_r;
    chk_hi_nxt = chk_hi_r;
    chk_lo_nxt = chk_lo_r;
    if (job_push) begin
      if (in_end) begin
        first_nxt  = 1'b1;
        odd_nxt    = 1'b0;
        chk_hi_nxt = 8'h00;
        chk_lo_nxt = 8'h00;
      end else begin
        first_nxt  = 1'b0;
        odd_nxt    = !odd_r;
        chk_hi_nxt = hi_upd;
        chk_lo_nxt = lo_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      odd_r    <= 1'b0;
      chk_hi_r <= 8'h00;
      chk_lo_r <= 8'h00;
    end else begin
      first_r  <= first_nxt;
      odd_r    <= odd_nxt;
      chk_hi_r <= chk_hi_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

endmodule

### design/fsx_queue.sv
// Two-entry job queue between front and back end.
// Uses fsx_pkg for the job record.
`timescale 1ns / 1ps

module fsx_queue
  import fsx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_data
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/fsx_back.sv
// Back end: walks each job through start, data, checksum and end phases,
// one line byte per cycle unless stalled, into an output register. Uses fsx_pkg.
`timescale 1ns / 1ps

module fsx_back
  import fsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job_data,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_done
);

  phase_t     phase_r, phase_nxt, cur_phase, adv_phase;
  logic       in_job_r, in_job_nxt;
  logic       esc2_r, esc2_nxt;
  logic       ov_r;
  logic [7:0] ob_r;
  logic       ol_r, od_r;
  logic       fire, raw, job_end;
  logic [7:0] value, line;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_done  = od_r;

  assign fire      = job_valid && (!ov_r || out_ready);
  assign cur_phase = in_job_r ? phase_r : (job_data.start ? PH_START : PH_DATA);

  // Pick the byte of this phase and the phase that follows it
  always_comb begin
    raw       = 1'b0;
    value     = job_data.data;
    adv_phase = cur_phase;
    job_end   = 1'b0;
    case (cur_phase)
      PH_START: begin
        raw       = 1'b1;
        value     = START_BYTE;
        adv_phase = PH_DATA;
      end
      PH_DATA: begin
        value     = job_data.data;
        adv_phase = PH_CHI;
        job_end   = !job_data.last;
      end
      PH_CHI: begin
        value     = job_data.chk_hi;
        adv_phase = PH_CLO;
      end
      PH_CLO: begin
        value     = job_data.chk_lo;
        adv_phase = PH_END;
      end
      PH_END: begin
        raw     = 1'b1;
        value   = END_BYTE;
        job_end = 1'b1;
      end
      default: begin
        raw     = 1'b1;
        job_end = 1'b1;
      end
    endcase
  end

  // Split each escaped byte into the escape byte and its code; retire the job on its last byte
  always_comb begin
    phase_nxt  = phase_r;
    in_job_nxt = in_job_r;
    esc2_nxt   = esc2_r;
    job_pop    = 1'b0;
    line       = value;
    if (!raw && needs_esc(value) && !esc2_r) begin
      line = ESC_BYTE;
      if (fire) begin
        esc2_nxt   = 1'b1;
        in_job_nxt = 1'b1;
        phase_nxt  = cur_phase;
      end
    end else begin
      line = esc2_r ? esc_code(value) : value;
      if (fire) begin
        esc2_nxt = 1'b0;
        if (job_end) begin
          job_pop    = 1'b1;
          in_job_nxt = 1'b0;
        end else begin
          in_job_nxt = 1'b1;
          phase_nxt  = adv_phase;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      in_job_r <= 1'b0;
      esc2_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      in_job_r <= in_job_nxt;
      esc2_r   <= esc2_nxt;
      if (fire) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (fire) begin
      ob_r <= line;
      ol_r <= job_pop;
      od_r <= (cur_phase == PH_END);
    end
  end

endmodule

### design/frame_stuff_xor_encoder.sv
// Framing encoder: takes one payload byte per request and sends the framed
// line stream, one line byte per cycle unless stalled, from an output
// register. A byte that needs no escape gives one line byte; an escaped byte
// gives two; the first byte of a packet adds the start byte and the last adds
// up to five more (escaped checksum bytes and the end byte), so an item gives
// 1 to 8 line bytes. A two-entry job queue lets input be taken while output
// is stalled.
`timescale 1ns / 1ps

module frame_stuff_xor_encoder
  import fsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic       in_tlast,   // packet_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // [0] frame_done
);

  logic job_push, job_full, job_pop, job_valid;
  job_t job_in, job_head;

  fsx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  fsx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job_in),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (job_head)
  );

  fsx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_data  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

endmodule

### design/fsx_checker.sv
// Port checker for the framing encoder, bound to the top level.
// Uses fsx_pkg for the framing byte constants.
`timescale 1ns / 1ps

module fsx_checker
  import fsx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // End of frame is the end byte and closes the run
  a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == END_BYTE && out_tlast)
    else $error("frame_done not on a closing end byte");

  // Stuffing keeps the end byte out of the data
  a_end_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == END_BYTE |-> out_tuser)
    else $error("raw end byte inside a frame");

  // Start byte never ends a run
  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == START_BYTE |-> !out_tlast)
    else $error("start byte marked as last");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("valid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("data changed under stall");

endmodule

bind frame_stuff_xor_encoder fsx_checker u_fsx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### bench/fsx_frame_checker.sv
// Checker for the framing encoder: watches the request and line channels,
// predicts the framed bytes of every accepted payload byte and compares them in order.
// Depends on fsx_pkg for the framing byte constants.
`timescale 1ns / 1ps

module fsx_frame_checker
  import fsx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic       in_tlast,   // packet_end
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] line_byte
  input  logic       out_tlast,  // run_last
  input  logic       out_tuser,  // [0] frame_done
  output int         fail_count,
  output int         lines_due
);

  typedef struct {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
  } line_rec_t;

  // Expected line bytes, oldest first
  line_rec_t line_q[$];

  // Predicted encoder state
  logic       awaiting_sof;
  logic       parity_odd;
  logic [7:0] sum_hi;
  logic [7:0] sum_lo;

  task automatic put_line(input logic [7:0] b, input logic tail, input logic done);
    line_rec_t rec;
    rec.line_byte  = b;
    rec.run_last   = tail;
    rec.frame_done = done;
    line_q = {line_q, rec};
  endtask

  // Stuff one byte; tail marks the last piece as the end of the request's output
  task automatic put_stuffed(input logic [7:0] b, input logic tail);
    if (b == ALT_BYTE) begin
      put_line(ESC_BYTE, 1'b0, 1'b0);
      put_line(ALT_CODE, tail, 1'b0);
    end else if (b >= ESC_BYTE) begin
      put_line(ESC_BYTE, 1'b0, 1'b0);
      put_line(b - ESC_BYTE, tail, 1'b0);
    end else begin
      put_line(b, tail, 1'b0);
    end
  endtask

  // Work out the line bytes caused by one payload byte and advance the state
  task automatic frame_payload(input logic [7:0] b, input logic pkt_end);
    if (awaiting_sof) begin
      put_line(START_BYTE, 1'b0, 1'b0);
      awaiting_sof = 1'b0;
    end
    if (parity_odd) begin
      sum_lo = sum_lo ^ b;
    end else begin
      sum_hi = sum_hi ^ b;
    end
    parity_odd = ~parity_odd;
    put_stuffed(b, ~pkt_end);
    if (pkt_end) begin
      put_stuffed(sum_hi, 1'b0);
      put_stuffed(sum_lo, 1'b0);
      put_line(END_BYTE, 1'b1, 1'b1);
      awaiting_sof = 1'b1;
      parity_odd   = 1'b0;
      sum_hi       = 8'h00;
      sum_lo       = 8'h00;
    end
  endtask

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  // Predict on accepted requests, then compare accepted line bytes
  always @(posedge clk) begin : watch
    line_rec_t want;
    if (!rst_n) begin
      awaiting_sof = 1'b1;
      parity_odd   = 1'b0;
      sum_hi       = 8'h00;
      sum_lo       = 8'h00;
      fail_count   = 0;
      line_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        frame_payload(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (line_q.size() == 0) begin
          flag_failure($sformatf("unexpected line byte %02h last=%b done=%b",
                                 out_tdata, out_tlast, out_tuser));
        end else begin
          want = line_q.pop_front();
          if (out_tdata !== want.line_byte || out_tlast !== want.run_last ||
              out_tuser !== want.frame_done) begin
            flag_failure($sformatf(
              "expected byte %02h last=%b done=%b, got byte %02h last=%b done=%b",
              want.line_byte, want.run_last, want.frame_done,
              out_tdata, out_tlast, out_tuser));
          end
        end
      end
    end
    lines_due = line_q.size();
  end

endmodule

### bench/tb_top.sv
// Top of the framing encoder bench: clock, reset, payload requests and line-side
// back-pressure, with the verdict. Depends on fsx_pkg, frame_stuff_xor_encoder and
// fsx_frame_checker.
`timescale 1ns / 1ps

module tb_top;
  import fsx_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] payload_byte
  logic       in_tlast;   // packet_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] line_byte
  logic       out_tlast;  // run_last
  logic       out_tuser;  // [0] frame_done

  int fail_count;
  int lines_due;

  // Idle limits per side, and a one-shot long hold for the line side
  int tx_gap_max = 10;
  int rx_gap_max = 10;
  int rx_hold    = 0;
  int sent       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_stuff_xor_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  fsx_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .lines_due  (lines_due)
  );

  // Offer one payload byte after a random gap; return at the falling edge after acceptance
  task automatic send_payload(input logic [7:0] b, input logic pkt_end);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= pkt_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Random payload byte, weighted toward the escaped values and their neighbors
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(9, 0))
      0: b = ALT_BYTE;
      1: b = ESC_BYTE;
      2: b = END_BYTE;
      3: b = START_BYTE;
      4: b = 8'hFC + 8'($urandom_range(3, 0));
      5: b = 8'hCB + 8'($urandom_range(2, 0));
      default: b = 8'($urandom_range(255, 0));
    endcase
    return b;
  endfunction

  // Line side: stall a random number of cycles before each line byte
  initial begin : line_sink
    int stall;
    bit hold_taken;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (rx_hold > 0 && !hold_taken) begin
        stall      = rx_hold;
        hold_taken = 1'b1;
      end else begin
        stall = $urandom_range(rx_gap_max, 0);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Payload side: directed packets, then random packets in phases
  initial begin : payload_source
    int plen;
    bit pause_done;
    pause_done = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // One-byte packets: plain zero, and an all-escape byte
    send_payload(8'h00, 1'b1);
    send_payload(START_BYTE, 1'b1);
    // Every escaped value and its neighbors in one packet
    send_payload(ALT_BYTE, 1'b0);
    send_payload(ESC_BYTE, 1'b0);
    send_payload(END_BYTE, 1'b0);
    send_payload(START_BYTE, 1'b0);
    send_payload(8'h7F, 1'b0);
    send_payload(8'h80, 1'b0);
    send_payload(8'h01, 1'b0);
    send_payload(8'hFC, 1'b0);
    send_payload(8'hCB, 1'b0);
    send_payload(8'hCD, 1'b0);
    send_payload(8'hAA, 1'b0);
    send_payload(8'h55, 1'b1);
    // Checksum bytes that need escaping themselves
    send_payload(ALT_BYTE, 1'b1);
    send_payload(8'h00, 1'b0);
    send_payload(END_BYTE, 1'b1);
    send_payload(ESC_BYTE, 1'b0);
    send_payload(ALT_BYTE, 1'b1);

    while (sent < 180) begin
      // Phase switches on the running request count
      if (sent >= 50 && sent < 80) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else if (sent >= 100 && sent < 130) begin
        tx_gap_max = 0;
        rx_gap_max = 10;
      end else begin
        tx_gap_max = 10;
        rx_gap_max = 10;
      end
      if (sent >= 100 && rx_hold == 0) begin
        rx_hold = 300;
      end
      if (sent >= 140 && !pause_done) begin
        // Hold off the payload side until the line side has caught up
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (lines_due != 0) @(negedge clk);
      end
      plen = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      for (int i = 0; i < plen; i++) begin
        send_payload(pick_payload(), i == plen - 1);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any extra line bytes
    while (lines_due != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && lines_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### frame_stuff_xor_encoder.f
design/fsx_pkg.sv
design/fsx_front.sv
design/fsx_queue.sv
design/fsx_back.sv
design/frame_stuff_xor_encoder.sv
design/fsx_checker.sv
bench/fsx_frame_checker.sv
bench/tb_top.sv
